@@ design/lkvc_pkg.sv @@
// shared constants and types for the lru key-value cache
package lkvc_pkg;

  // store geometry and field widths
  localparam int ENTRIES = 16;
  localparam int KEY_W   = 16;
  localparam int DATA_W  = 32;
  localparam int CAP_W   = 5;
  localparam int RANK_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W   = $clog2(ENTRIES + 1);

  // capacity after reset
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  // action codes
  localparam logic ACT_GET = 1'b0;
  localparam logic ACT_PUT = 1'b1;

  // request held in the input register
  typedef struct packed {
    logic              valid;
    logic              action;
    logic [KEY_W-1:0]  key;
    logic [DATA_W-1:0] value;
  } lkvc_req_t;

  // outcome of the associative lookup
  typedef struct packed {
    logic               hit;
    logic [ENTRIES-1:0] match;
    logic [RANK_W-1:0]  rank;
    logic [DATA_W-1:0]  data;
  } lkvc_hit_t;

endpackage

@@ design/lru_key_value_cache.sv @@
// top level of the lru key-value cache: request, result and capacity registers
// Fully associative 16-entry key-value cache with least-recently-used
// replacement. An item is taken on every clock edge with start high (busy
// is always low), so the block runs at one item per cycle; the result of a
// get appears on out_hit/out_data with out_valid high for one cycle: the
// item is held in the request register while the key compare and rank
// update settle into the result register. Puts give no result. Results
// cannot be held off. A get that misses returns out_hit low and out_data
// zero. capacity (cfg_data, reset 16, values above 16 act as 16) is
// written through cfg_valid/cfg_ready, with cfg_ready always high, and
// should be changed only while no item is in flight.
module lru_key_value_cache import lkvc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic              in_action,
  input  logic [KEY_W-1:0]  in_key,
  input  logic [DATA_W-1:0] in_value,
  output logic              out_valid,
  output logic              out_hit,
  output logic [DATA_W-1:0] out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CAP_W-1:0]  cfg_data
);

  lkvc_req_t         req_r;
  logic [CAP_W-1:0]  capacity_r;
  logic [CNT_W-1:0]  cap_eff;
  lkvc_hit_t         lk;
  logic              out_valid_r;
  logic              out_valid_nxt;
  logic              out_hit_r;
  logic [DATA_W-1:0] out_data_r;

  // always ready for the next item and for a capacity write
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // capacity register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= CAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      capacity_r <= cfg_data;
    end
  end

  // capacity saturates at the number of entries
  always_comb begin
    if (int'(capacity_r) > ENTRIES) begin
      cap_eff = CNT_W'(ENTRIES);
    end else begin
      cap_eff = CNT_W'(capacity_r);
    end
  end

  // request register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_r.valid <= 1'b0;
    end else begin
      req_r.valid <= start && !busy;
    end
    req_r.action <= in_action;
    req_r.key    <= in_key;
    req_r.value  <= in_value;
  end

  // storage and update
  lkvc_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (req_r),
    .cap_eff (cap_eff),
    .lk      (lk)
  );

  // result register, one strobe per get
  assign out_valid_nxt = req_r.valid && (req_r.action == ACT_GET);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    out_hit_r  <= lk.hit;
    out_data_r <= lk.hit ? lk.data : '0;
  end

  assign out_valid = out_valid_r;
  assign out_hit   = out_hit_r;
  assign out_data  = out_data_r;

endmodule

@@ design/lkvc_lookup.sv @@
// parallel key compare over all entries with one-hot read of rank and data
module lkvc_lookup import lkvc_pkg::*; (
  input  logic [KEY_W-1:0]   key,
  input  logic [ENTRIES-1:0] valid,
  input  logic [KEY_W-1:0]   keys  [ENTRIES],
  input  logic [RANK_W-1:0]  ranks [ENTRIES],
  input  logic [DATA_W-1:0]  datas [ENTRIES],
  output lkvc_hit_t          res
);

  // compare every entry, or together the fields of the matching one
  always_comb begin
    res = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (valid[i] && (keys[i] == key)) begin
        res.match[i] = 1'b1;
        res.rank     = res.rank | ranks[i];
        res.data     = res.data | datas[i];
      end
    end
    res.hit = |res.match;
  end

endmodule

@@ design/lkvc_store.sv @@
// entry storage, recency ranks and the get/put update
module lkvc_store import lkvc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  lkvc_req_t        req,
  input  logic [CNT_W-1:0] cap_eff,
  output lkvc_hit_t        lk
);

  logic [ENTRIES-1:0] valid_r;
  logic [ENTRIES-1:0] valid_nxt;
  logic [KEY_W-1:0]   key_r  [ENTRIES];
  logic [DATA_W-1:0]  data_r [ENTRIES];
  logic [RANK_W-1:0]  rank_r [ENTRIES];
  logic [RANK_W-1:0]  rank_nxt [ENTRIES];
  logic [CNT_W-1:0]   occ_r;
  logic [CNT_W-1:0]   occ_nxt;

  logic [ENTRIES-1:0] valid1;
  logic [ENTRIES-1:0] valid2;
  logic [ENTRIES-1:0] cand;
  logic [ENTRIES-1:0] victim;
  logic [ENTRIES-1:0] free_slot;
  logic [ENTRIES-1:0] wr_en;
  logic [RANK_W-1:0]  rank1 [ENTRIES];
  logic [RANK_W-1:0]  old_rank;
  logic [CNT_W-1:0]   occ1;
  logic               do_evict;
  logic               do_insert;

  // associative lookup of the request key
  lkvc_lookup u_lookup (
    .key   (req.key),
    .valid (valid_r),
    .keys  (key_r),
    .ranks (rank_r),
    .datas (data_r),
    .res   (lk)
  );

  // state after dropping a present key
  always_comb begin
    valid1 = valid_r & ~lk.match;
    occ1   = occ_r - CNT_W'(lk.hit);
    for (int i = 0; i < ENTRIES; i++) begin
      if (lk.hit && (rank_r[i] > lk.rank)) begin
        rank1[i] = rank_r[i] - RANK_W'(1);
      end else begin
        rank1[i] = rank_r[i];
      end
    end
  end

  // pick the least recent entry when full, then the lowest free slot
  always_comb begin
    old_rank = RANK_W'(occ1 - CNT_W'(1));
    do_evict = (occ1 >= cap_eff);
    for (int i = 0; i < ENTRIES; i++) begin
      cand[i] = valid1[i] && (rank1[i] == old_rank);
    end
    victim    = do_evict ? (cand & (~cand + ENTRIES'(1))) : '0;
    valid2    = valid1 & ~victim;
    free_slot = ~valid2 & (valid2 + ENTRIES'(1));
    do_insert = req.valid && (req.action == ACT_PUT) && (cap_eff != '0);
    wr_en     = do_insert ? free_slot : '0;
  end

  // next valid set, ranks and occupancy
  always_comb begin
    valid_nxt = valid_r;
    occ_nxt   = occ_r;
    rank_nxt  = rank_r;
    if (req.valid) begin
      if (req.action == ACT_GET) begin
        if (lk.hit) begin
          for (int i = 0; i < ENTRIES; i++) begin
            if (lk.match[i]) begin
              rank_nxt[i] = '0;
            end else if (valid_r[i] && (rank_r[i] < lk.rank)) begin
              rank_nxt[i] = rank_r[i] + RANK_W'(1);
            end
          end
        end
      end else if (cap_eff == '0) begin
        valid_nxt = valid1;
        occ_nxt   = occ1;
        rank_nxt  = rank1;
      end else begin
        valid_nxt = valid2 | free_slot;
        occ_nxt   = occ1 - CNT_W'(do_evict) + CNT_W'(1);
        for (int i = 0; i < ENTRIES; i++) begin
          rank_nxt[i] = free_slot[i] ? '0 : (rank1[i] + RANK_W'(1));
        end
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      occ_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      occ_r   <= occ_nxt;
    end
  end

  // entry payload and ranks
  always_ff @(posedge clk) begin
    rank_r <= rank_nxt;
    for (int i = 0; i < ENTRIES; i++) begin
      if (wr_en[i]) begin
        key_r[i]  <= req.key;
        data_r[i] <= req.value;
      end
    end
  end

`ifndef NO_ASSERTIONS
  // occupancy tracks the number of valid entries
  a_occ_count: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r == CNT_W'($countones(valid_r)))
    else $error("occupancy out of step with valid entries");

  // a key is never held twice
  a_one_match: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(lk.match))
    else $error("key matches more than one entry");

  // a get never changes which entries are held
  a_get_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    req.valid && (req.action == ACT_GET) |=> $stable(valid_r) && $stable(occ_r))
    else $error("get changed the entry set");
`endif

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// self-checking testbench for the lru key-value cache: directed table, then randomized gets/puts
module tb_top import lkvc_pkg::*; ();

  localparam int DRAIN_CYCLES    = 4;
  localparam int ITEMS_PER_PHASE = 150;
  localparam int KEY_POOL        = 24;

  // expected outcome of one get
  typedef struct packed {
    logic              hit;
    logic [DATA_W-1:0] data;
  } lookup_t;

  typedef enum logic {ROW_ACCESS, ROW_CAPACITY} row_kind_t;

  // one row of the directed table; value carries the capacity on capacity rows
  typedef struct packed {
    row_kind_t         kind;
    logic              act;
    logic [KEY_W-1:0]  key;
    logic [DATA_W-1:0] value;
    bit                typed;
    lookup_t           want;
  } dir_row_t;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              start     = 1'b0;
  logic              busy;
  logic              in_action = ACT_GET;
  logic [KEY_W-1:0]  in_key    = '0;
  logic [DATA_W-1:0] in_value  = '0;
  logic              out_valid;
  logic              out_hit;
  logic [DATA_W-1:0] out_data;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CAP_W-1:0]  cfg_data  = '0;

  // predicted cache contents
  bit                line_valid [ENTRIES];
  logic [KEY_W-1:0]  line_key   [ENTRIES];
  logic [DATA_W-1:0] line_data  [ENTRIES];
  int                line_age   [ENTRIES];
  int                line_count = 0;
  logic [CAP_W-1:0]  cap_setting = CAP_RESET;

  lookup_t           expected_lookups [$];
  dir_row_t          dir_rows [$];
  int                phase_caps [$] = '{1, 31, 0, 4, 16, 2, 17, 8, 15, 3, 16, 9};
  logic [KEY_W-1:0]  key_pool [KEY_POOL];

  int fail_count  = 0;
  int checked     = 0;
  int gets_sent   = 0;
  int hits_sent   = 0;
  int puts_sent   = 0;
  int cap_writes  = 0;
  int burst_left  = 0;

  lru_key_value_cache uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_action (in_action),
    .in_key    (in_key),
    .in_value  (in_value),
    .out_valid (out_valid),
    .out_hit   (out_hit),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // drop one line and close the gap in the recency order
  function automatic void drop_line(int idx);
    int age;
    age = line_age[idx];
    line_valid[idx] = 1'b0;
    for (int j = 0; j < ENTRIES; j++)
      if (line_valid[j] && line_age[j] > age) line_age[j]--;
    if (line_count > 0) line_count--;
  endfunction

  // apply one access to the predicted cache; returns 1 when a result is due
  function automatic bit cache_access(input logic act, input logic [KEY_W-1:0] k,
                                      input logic [DATA_W-1:0] v, output lookup_t res);
    int found, victim, slot, age, eff_cap;
    found = -1;
    for (int j = 0; j < ENTRIES; j++)
      if (found < 0 && line_valid[j] && line_key[j] == k) found = j;
    eff_cap = (int'(cap_setting) > ENTRIES) ? ENTRIES : int'(cap_setting);
    res = '0;
    // get: report and promote to most recent
    if (act == ACT_GET) begin
      if (found >= 0) begin
        age = line_age[found];
        for (int j = 0; j < ENTRIES; j++)
          if (line_valid[j] && line_age[j] < age) line_age[j]++;
        line_age[found] = 0;
        res.hit  = 1'b1;
        res.data = line_data[found];
      end
      return 1'b1;
    end
    // put: remove old copy, make room, insert as most recent
    if (found >= 0) drop_line(found);
    if (eff_cap == 0) return 1'b0;
    if (line_count >= eff_cap) begin
      victim = -1;
      for (int j = 0; j < ENTRIES; j++)
        if (line_valid[j] && (victim < 0 || line_age[j] > line_age[victim])) victim = j;
      if (victim >= 0) drop_line(victim);
    end
    slot = -1;
    for (int j = 0; j < ENTRIES; j++)
      if (slot < 0 && !line_valid[j]) slot = j;
    if (slot < 0) return 1'b0;
    for (int j = 0; j < ENTRIES; j++)
      if (line_valid[j]) line_age[j]++;
    line_valid[slot] = 1'b1;
    line_key[slot]   = k;
    line_data[slot]  = v;
    line_age[slot]   = 0;
    line_count++;
    return 1'b0;
  endfunction

  function automatic void add_row(row_kind_t kind, logic act, logic [KEY_W-1:0] k,
                                  logic [DATA_W-1:0] v, bit typed, logic hit,
                                  logic [DATA_W-1:0] d);
    dir_row_t r;
    r.kind      = kind;
    r.act       = act;
    r.key       = k;
    r.value     = v;
    r.typed     = typed;
    r.want.hit  = hit;
    r.want.data = d;
    dir_rows.push_back(r);
  endfunction

  // present one item and wait until the block takes it
  task automatic send_item(input logic act, input logic [KEY_W-1:0] k,
                           input logic [DATA_W-1:0] v, input bit use_typed,
                           input lookup_t typed_want);
    lookup_t res;
    bit gives;
    start     <= 1'b1;
    in_action <= act;
    in_key    <= k;
    in_value  <= v;
    do @(posedge clk); while (busy);
    gives = cache_access(act, k, v, res);
    if (gives) begin
      expected_lookups.push_back(use_typed ? typed_want : res);
      gets_sent++;
      if (res.hit) hits_sent++;
    end else begin
      puts_sent++;
    end
  endtask

  // bursts of back-to-back items with random gaps between them
  task automatic pace_sender();
    int gap;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // capacity write once the pipeline is empty
  task automatic write_capacity(input logic [CAP_W-1:0] c);
    start <= 1'b0;
    while (expected_lookups.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= c;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid   <= 1'b0;
    cap_setting = c;
    cap_writes++;
  endtask

  // compare each result with the oldest pending lookup
  always @(posedge clk) begin : result_check
    lookup_t want;
    if (rst_n && out_valid) begin
      if (expected_lookups.size() == 0) begin
        $error("unexpected result: out_hit %0b out_data %h", out_hit, out_data);
        fail_count++;
      end else begin
        want = expected_lookups.pop_front();
        if (out_hit !== want.hit) begin
          $error("out_hit mismatch: expected %0b actual %0b", want.hit, out_hit);
          fail_count++;
        end
        if (out_data !== want.data) begin
          $error("out_data mismatch: expected %h actual %h", want.data, out_data);
          fail_count++;
        end
        checked++;
      end
    end
  end

  // run limit
  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // stimulus
  initial begin : stimulus
    lookup_t          none;
    logic             act;
    logic [KEY_W-1:0] k;
    logic [DATA_W-1:0] v;
    int               waited;
    none = '0;
    for (int j = 0; j < ENTRIES; j++) begin
      line_valid[j] = 1'b0;
      line_key[j]   = '0;
      line_data[j]  = '0;
      line_age[j]   = 0;
    end
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int j = 2; j < KEY_POOL; j++) key_pool[j] = KEY_W'($urandom_range(0, 65535));
    phase_caps.push_back($urandom_range(0, 31));

    // directed table: empty store, key and value extremes, update in place
    add_row(ROW_ACCESS,   ACT_GET, 16'h0000, 32'h0,        1, 1'b0, 32'h0);
    add_row(ROW_ACCESS,   ACT_GET, 16'hFFFF, 32'hFFFFFFFF, 1, 1'b0, 32'h0);
    add_row(ROW_ACCESS,   ACT_PUT, 16'h0000, 32'hFFFFFFFF, 0, 1'b0, 32'h0);
    add_row(ROW_ACCESS,   ACT_PUT, 16'hFFFF, 32'h00000000, 0, 1'b0, 32'h0);
    add_row(ROW_ACCESS,   ACT_GET, 16'h0000, 32'h0,        1, 1'b1, 32'hFFFFFFFF);
    add_row(ROW_ACCESS,   ACT_GET, 16'hFFFF, 32'h0,        1, 1'b1, 32'h00000000);
    add_row(ROW_ACCESS,   ACT_PUT, 16'h0000, 32'h12345678, 0, 1'b0, 32'h0);
    add_row(ROW_ACCESS,   ACT_GET, 16'h0000, 32'h0,        1, 1'b1, 32'h12345678);
    add_row(ROW_ACCESS,   ACT_GET, 16'h5555, 32'h0,        1, 1'b0, 32'h0);
    // capacity lowered to occupancy: next new key evicts the least recent
    add_row(ROW_CAPACITY, ACT_PUT, 16'h0000, 32'd2,        0, 1'b0, 32'h0);
    add_row(ROW_ACCESS,   ACT_PUT, 16'h0010, 32'hA0A0A0A0, 0, 1'b0, 32'h0);
    add_row(ROW_ACCESS,   ACT_GET, 16'hFFFF, 32'h0,        0, 1'b0, 32'h0);
    add_row(ROW_ACCESS,   ACT_GET, 16'h0000, 32'h0,        0, 1'b0, 32'h0);
    add_row(ROW_ACCESS,   ACT_PUT, 16'h0010, 32'h5A5A5A5A, 0, 1'b0, 32'h0);
    // capacity below occupancy: re-put of a present key also evicts
    add_row(ROW_CAPACITY, ACT_PUT, 16'h0000, 32'd1,        0, 1'b0, 32'h0);
    add_row(ROW_ACCESS,   ACT_PUT, 16'h0000, 32'hC3C3C3C3, 0, 1'b0, 32'h0);
    add_row(ROW_ACCESS,   ACT_GET, 16'h0010, 32'h0,        0, 1'b0, 32'h0);
    // zero capacity: put removes the key and stores nothing
    add_row(ROW_CAPACITY, ACT_PUT, 16'h0000, 32'd0,        0, 1'b0, 32'h0);
    add_row(ROW_ACCESS,   ACT_PUT, 16'h0000, 32'h00000001, 0, 1'b0, 32'h0);
    add_row(ROW_ACCESS,   ACT_GET, 16'h0000, 32'h0,        1, 1'b0, 32'h0);
    // capacity above the entry count saturates
    add_row(ROW_CAPACITY, ACT_PUT, 16'h0000, 32'd31,       0, 1'b0, 32'h0);
    add_row(ROW_ACCESS,   ACT_PUT, 16'h0007, 32'hFFFFFFFF, 0, 1'b0, 32'h0);
    add_row(ROW_ACCESS,   ACT_GET, 16'h0007, 32'h0,        1, 1'b1, 32'hFFFFFFFF);

    // reset
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CAPACITY) begin
        write_capacity(dir_rows[i].value[CAP_W-1:0]);
      end else begin
        send_item(dir_rows[i].act, dir_rows[i].key, dir_rows[i].value,
                  dir_rows[i].typed, dir_rows[i].want);
        pace_sender();
      end
    end

    // random part: keys mostly from a small pool so hits and evictions are common
    for (int p = 0; p < phase_caps.size(); p++) begin
      write_capacity(CAP_W'(phase_caps[p]));
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        act = ($urandom_range(0, 99) < 50) ? ACT_PUT : ACT_GET;
        if ($urandom_range(0, 99) < 85) k = key_pool[$urandom_range(0, KEY_POOL - 1)];
        else k = KEY_W'($urandom_range(0, 65535));
        case ($urandom_range(0, 9))
          0: v = '0;
          1: v = '1;
          default: v = $urandom;
        endcase
        send_item(act, k, v, 1'b0, none);
        pace_sender();
      end
    end

    // drain
    start <= 1'b0;
    waited = 0;
    while (expected_lookups.size() != 0 && waited < 2000) begin
      @(posedge clk);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_lookups.size() != 0) begin
      $error("%0d lookups never returned a result", expected_lookups.size());
      fail_count++;
    end

    $display("covered %0d gets (%0d hits expected, %0d results checked) and %0d puts",
             gets_sent, hits_sent, checked, puts_sent);
    $display("over %0d capacity writes including 0, 1 and values above the entry count",
             cap_writes);
    if (fail_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

@@ filelist.f @@
design/lkvc_pkg.sv
design/lkvc_lookup.sv
design/lkvc_store.sv
design/lru_key_value_cache.sv
tb/tb_top.sv
